// File: hdl/trlm_pkg.sv
// ----------------------------------------------------------------------------
// trlm_pkg
// shared types and codes of the region lock manager: request fields,
// standby entries and the standby cell controls
// ----------------------------------------------------------------------------
package trlm_pkg;

	localparam int TIME_W   = 32;
	localparam int REGION_W = 6;
	localparam int SET_SIZE = 4;
	localparam int IDX_W    = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
	localparam int N_W      = $clog2(SET_SIZE + 1);
	localparam int GCNT_W   = $clog2(SET_SIZE + 2);

	localparam logic [TIME_W-1:0] NO_WRITE = 32'h7fff_ffff;

	// operation codes
	localparam logic [1:0] OP_CREATE  = 2'd0;
	localparam logic [1:0] OP_OBTAIN  = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_GRANTED   = 2'd0;
	localparam logic [1:0] STAT_WAITING   = 2'd1;
	localparam logic [1:0] STAT_NO_REGION = 2'd2;
	localparam logic [1:0] STAT_NO_ROOM   = 2'd3;

	typedef struct packed {
		logic [REGION_W-1:0] region;
		logic                wr;
	} elem_t;

	typedef struct packed {
		logic                       valid;
		logic [TIME_W-1:0]          ticket;
		logic [N_W-1:0]             n;
		elem_t [SET_SIZE-1:0]       e;
	} sb_entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD    = 2'd0,
		CELL_ROT     = 2'd1,
		CELL_COMPACT = 2'd2,
		CELL_ALLOC   = 2'd3
	} cell_mode_t;

endpackage

// File: hdl/trlm_cell.sv
// ----------------------------------------------------------------------------
// trlm_cell
// one standby slot; rotates, compacts toward the head or loads a new set
// ----------------------------------------------------------------------------
module trlm_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  trlm_pkg::cell_mode_t mode,
	input  trlm_pkg::sb_entry_t  nb_in,
	input  trlm_pkg::sb_entry_t  new_in,
	input  logic                 hole_in,
	output trlm_pkg::sb_entry_t  entry_out,
	output logic                 hole_out
);
	import trlm_pkg::*;

	sb_entry_t entry_q;
	logic      valid_q;
	logic      take_nb;
	logic      take_new;

	always_comb begin
		take_nb  = (mode == CELL_ROT) || ((mode == CELL_COMPACT) && (hole_in || !valid_q));
		take_new = (mode == CELL_ALLOC) && !valid_q && !hole_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_nb) begin
			valid_q <= nb_in.valid;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_nb) begin
			entry_q <= nb_in;
		end else if (take_new) begin
			entry_q <= new_in;
		end
	end

	always_comb begin
		entry_out       = entry_q;
		entry_out.valid = valid_q;
		hole_out        = hole_in || !valid_q;
	end

endmodule

// File: hdl/timestamp_region_lock_manager.sv
// ----------------------------------------------------------------------------
// timestamp_region_lock_manager
// timestamp ordered reader/writer lock manager over a table of regions
// ----------------------------------------------------------------------------
// usage
//   a request is taken when start is high and busy is low; operation selects
//   create region, obtain element or release element. obtain and release
//   elements are gathered into sets closed by set_end.
//   results leave on status/ticket/final_result, marked by done for exactly
//   one cycle; final_result flags the last result of a request. the receiver
//   cannot stall, so results are never held back.
// sequence
//   create and non-final obtain elements finish in the accept cycle (busy
//   stays low). a final obtain checks that every region is known, then
//   that each queue has room, queues each element and runs the grant test
//   per element; when standby is full, the set is taken back out of the
//   queues. a release pops the queue head; a write release then walks the
//   queued entries to find the next write. a final release rescans the
//   standby chain, rotating every slot past the head with a grant test per
//   valid set, then compacts it. each region memory has a single read port.
// reset
//   no region is valid, time is one, standby is empty. the queue memory is
//   not cleared; entries are written before they are read.
// ----------------------------------------------------------------------------
module timestamp_region_lock_manager #(
	parameter int NUM_REGIONS   = 64,
	parameter int QUEUE_DEPTH   = 16,
	parameter int STANDBY_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    operation,
	input  logic [trlm_pkg::REGION_W-1:0] region,
	input  logic                          is_write,
	input  logic                          set_end,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [trlm_pkg::TIME_W-1:0]   ticket,
	output logic                          final_result
);
	import trlm_pkg::*;

	localparam int RIW      = $clog2(NUM_REGIONS);
	localparam int QW       = $clog2(QUEUE_DEPTH);
	localparam int CW       = $clog2(QUEUE_DEPTH + 1);
	localparam int SW       = CW + 1;
	localparam int PQ_DEPTH = NUM_REGIONS * QUEUE_DEPTH;
	localparam int AW       = $clog2(PQ_DEPTH);
	localparam int RW       = $clog2(STANDBY_DEPTH + 1);

	typedef enum logic [19:0] {
		ST_IDLE     = 20'h00001,
		ST_F_START  = 20'h00002,
		ST_F_VCHK   = 20'h00004,
		ST_F_RCHK_A = 20'h00008,
		ST_F_RCHK_B = 20'h00010,
		ST_F_ENQ_A  = 20'h00020,
		ST_F_ENQ_B  = 20'h00040,
		ST_G_A      = 20'h00080,
		ST_G_B      = 20'h00100,
		ST_G_C      = 20'h00200,
		ST_G_D      = 20'h00400,
		ST_W_A      = 20'h00800,
		ST_W_B      = 20'h01000,
		ST_R_A      = 20'h02000,
		ST_R_B      = 20'h04000,
		ST_R_SCAN_A = 20'h08000,
		ST_R_SCAN_B = 20'h10000,
		ST_R_SCAN_C = 20'h20000,
		ST_S_HEAD   = 20'h40000,
		ST_S_COMP   = 20'h80000
	} state_t;

	// ring slot arithmetic, sum stays below twice the depth
	function automatic logic [QW-1:0] ring_add(input logic [QW-1:0] a, input logic [CW-1:0] b);
		logic [SW-1:0] s;
		s = SW'(a) + SW'(b);
		if (s >= SW'(QUEUE_DEPTH)) begin
			s = s - SW'(QUEUE_DEPTH);
		end
		return QW'(s);
	endfunction

	function automatic logic [AW-1:0] qaddr(input logic [RIW-1:0] r, input logic [QW-1:0] s);
		return AW'(r) * AW'(QUEUE_DEPTH) + AW'(s);
	endfunction

	// control state
	state_t            state_q;
	logic              region_valid_q [NUM_REGIONS];
	logic [TIME_W-1:0] time_q;
	logic [GCNT_W-1:0] gcnt_q;
	logic [N_W-1:0]    n_q;
	logic [IDX_W-1:0]  idx_q;
	logic              mode_rescan_q;
	logic [RW-1:0]     rot_q;
	logic              pend_q;
	logic              done_q;

	// payload
	elem_t             gset_q  [SET_SIZE];
	logic [TIME_W-1:0] saved_q [SET_SIZE];
	logic [REGION_W-1:0] rel_reg_q;
	logic              rel_wr_q;
	logic              rel_last_q;
	logic [QW-1:0]     rhead_q;
	logic [CW-1:0]     rcnt_q;
	logic [CW-1:0]     scan_i_q;
	logic [AW-1:0]     pq_addr_q;
	logic [TIME_W-1:0] pend_ticket_q;
	logic [1:0]        status_q;
	logic [TIME_W-1:0] ticket_q;
	logic              final_q;

	// region memories: queue ring, head/count, earliest pending write
	logic [TIME_W:0]   pq_mem   [PQ_DEPTH];
	logic [QW-1:0]     head_mem [NUM_REGIONS];
	logic [CW-1:0]     cnt_mem  [NUM_REGIONS];
	logic [TIME_W-1:0] ewt_mem  [NUM_REGIONS];
	logic [TIME_W:0]   pq_rd_q;
	logic [QW-1:0]     head_rd_q;
	logic [CW-1:0]     cnt_rd_q;
	logic [TIME_W-1:0] ewt_rd_q;

	// standby chain
	sb_entry_t  cell_w [STANDBY_DEPTH];
	logic       hole_w [STANDBY_DEPTH];
	cell_mode_t cell_mode;
	sb_entry_t  tail_in;
	sb_entry_t  new_entry;
	sb_entry_t  head;

	// combinational control
	logic [REGION_W-1:0] cur_reg;
	logic                cur_wr;
	logic [RIW-1:0]      ridx;
	logic [RIW-1:0]      in_ridx;
	logic                in_range;
	logic                cur_known;
	logic [TIME_W-1:0]   chk_ticket;
	logic [N_W-1:0]      chk_n;
	logic                chk_last;
	logic [N_W-1:0]      same;
	logic                g_ok;
	logic                g_fail;
	logic                g_pass;
	logic                g_go_pq;
	logic                chain_full;
	logic                create_new;
	logic                pop_any;
	logic                accept;
	logic [RIW-1:0]      w_ridx;
	logic                hc_we;
	logic [QW-1:0]       hc_head_wd;
	logic [CW-1:0]       hc_cnt_wd;
	logic                ewt_we;
	logic [TIME_W-1:0]   ewt_wd;
	logic                pq_we;
	logic [AW-1:0]       pq_waddr;
	logic [TIME_W:0]     pq_wd;
	logic                sb_packed;

	assign accept = start && (state_q == ST_IDLE);
	assign head   = cell_w[0];

	always_comb begin
		// element under work: release register, head standby set or gathered set
		if (state_q inside {ST_R_A, ST_R_B, ST_R_SCAN_A, ST_R_SCAN_B, ST_R_SCAN_C}) begin
			cur_reg = rel_reg_q;
			cur_wr  = rel_wr_q;
		end else if (mode_rescan_q) begin
			cur_reg = head.e[idx_q].region;
			cur_wr  = head.e[idx_q].wr;
		end else begin
			cur_reg = gset_q[idx_q].region;
			cur_wr  = gset_q[idx_q].wr;
		end
		ridx      = RIW'(cur_reg);
		in_ridx   = RIW'(region);
		in_range  = (32'(region) < NUM_REGIONS);
		cur_known = (32'(cur_reg) < NUM_REGIONS) && region_valid_q[ridx];

		chk_ticket = mode_rescan_q ? head.ticket : time_q;
		chk_n      = mode_rescan_q ? head.n : n_q;
		chk_last   = ((N_W'(idx_q) + N_W'(1)) == chk_n);

		// entries of the gathered set that share this region
		same = '0;
		for (int j = 0; j < SET_SIZE; j++) begin
			if ((N_W'(j) < n_q) && (gset_q[j].region == cur_reg)) begin
				same = same + N_W'(1);
			end
		end

		// grant test of one element
		g_ok    = 1'b0;
		g_fail  = 1'b0;
		g_go_pq = 1'b0;
		if (state_q == ST_G_B) begin
			if (cur_wr) begin
				g_ok    = (cnt_rd_q == '0);
				g_go_pq = (cnt_rd_q != '0);
			end else begin
				g_ok   = (chk_ticket <= ewt_rd_q);
				g_fail = (chk_ticket > ewt_rd_q);
			end
		end else if (state_q == ST_G_D) begin
			g_ok   = (chk_ticket <= pq_rd_q[TIME_W-1:0]);
			g_fail = (chk_ticket > pq_rd_q[TIME_W-1:0]);
		end
		g_pass = g_ok && chk_last;

		chain_full = !hole_w[STANDBY_DEPTH-1];
		create_new = accept && (operation == OP_CREATE) && in_range
			&& !region_valid_q[in_ridx];
		pop_any    = (state_q == ST_R_B) && (cnt_rd_q != '0);

		// region memory writes
		w_ridx     = (state_q == ST_IDLE) ? in_ridx : ridx;
		hc_we      = 1'b0;
		hc_head_wd = head_rd_q;
		hc_cnt_wd  = cnt_rd_q;
		ewt_we     = 1'b0;
		ewt_wd     = '0;
		pq_we      = 1'b0;
		pq_waddr   = qaddr(ridx, ring_add(head_rd_q, cnt_rd_q));
		pq_wd      = {cur_wr, time_q};
		if (create_new) begin
			hc_we      = 1'b1;
			hc_head_wd = '0;
			hc_cnt_wd  = CW'(1);
			ewt_we     = 1'b1;
			pq_we      = 1'b1;
			pq_waddr   = qaddr(in_ridx, '0);
			pq_wd      = {1'b1, {TIME_W{1'b0}}};
		end else if (state_q == ST_F_ENQ_B) begin
			hc_we     = 1'b1;
			hc_cnt_wd = cnt_rd_q + CW'(1);
			pq_we     = 1'b1;
			if (cur_wr && (time_q < ewt_rd_q)) begin
				ewt_we = 1'b1;
				ewt_wd = time_q;
			end
		end else if (state_q == ST_W_B) begin
			hc_we     = 1'b1;
			hc_cnt_wd = cnt_rd_q - CW'(1);
			ewt_we    = 1'b1;
			ewt_wd    = saved_q[idx_q];
		end else if (pop_any) begin
			hc_we      = 1'b1;
			hc_head_wd = ring_add(head_rd_q, CW'(1));
			hc_cnt_wd  = cnt_rd_q - CW'(1);
			if (rel_wr_q) begin
				ewt_we = 1'b1;
				ewt_wd = NO_WRITE;
			end
		end else if ((state_q == ST_R_SCAN_C) && pq_rd_q[TIME_W]) begin
			ewt_we = 1'b1;
			ewt_wd = pq_rd_q[TIME_W-1:0];
		end

		// standby chain control
		new_entry        = head;
		new_entry.valid  = 1'b1;
		new_entry.ticket = time_q;
		new_entry.n      = n_q;
		for (int k = 0; k < SET_SIZE; k++) begin
			new_entry.e[k] = gset_q[k];
		end
		tail_in       = head;
		tail_in.valid = 1'b0;
		cell_mode     = CELL_HOLD;
		if ((state_q == ST_S_HEAD) && (rot_q != RW'(STANDBY_DEPTH)) && !head.valid) begin
			cell_mode = CELL_ROT;
		end else if (mode_rescan_q && (g_pass || g_fail)) begin
			cell_mode = CELL_ROT;
			// a set that stays waiting goes back in at the tail
			tail_in.valid = g_fail;
		end else if (!mode_rescan_q && g_fail && !chain_full) begin
			cell_mode = CELL_ALLOC;
		end else if (state_q == ST_S_COMP) begin
			cell_mode = CELL_COMPACT;
		end

		sb_packed = 1'b1;
		for (int i = 1; i < STANDBY_DEPTH; i++) begin
			if (hole_w[i-1] && cell_w[i].valid) begin
				sb_packed = 1'b0;
			end
		end
	end

	// standby chain, slot 0 is the oldest set
	for (genvar i = 0; i < STANDBY_DEPTH; i++) begin : g_cell
		sb_entry_t nb;
		logic      hin;
		if (i == STANDBY_DEPTH - 1) begin : g_tail
			assign nb = tail_in;
		end else begin : g_mid
			assign nb = cell_w[i+1];
		end
		if (i == 0) begin : g_first
			assign hin = 1'b0;
		end else begin : g_next
			assign hin = hole_w[i-1];
		end
		trlm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.mode      (cell_mode),
			.nb_in     (nb),
			.new_in    (new_entry),
			.hole_in   (hin),
			.entry_out (cell_w[i]),
			.hole_out  (hole_w[i])
		);
	end

	// region memories
	always_ff @(posedge clk) begin
		if (hc_we) begin
			head_mem[w_ridx] <= hc_head_wd;
			cnt_mem[w_ridx]  <= hc_cnt_wd;
		end
		if (ewt_we) begin
			ewt_mem[w_ridx] <= ewt_wd;
		end
		if (pq_we) begin
			pq_mem[pq_waddr] <= pq_wd;
		end
		head_rd_q <= head_mem[ridx];
		cnt_rd_q  <= cnt_mem[ridx];
		ewt_rd_q  <= ewt_mem[ridx];
		pq_rd_q   <= pq_mem[pq_addr_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			time_q        <= TIME_W'(1);
			gcnt_q        <= '0;
			n_q           <= '0;
			idx_q         <= '0;
			mode_rescan_q <= 1'b0;
			rot_q         <= '0;
			pend_q        <= 1'b0;
			done_q        <= 1'b0;
			for (int r = 0; r < NUM_REGIONS; r++) begin
				region_valid_q[r] <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (operation)
							OP_CREATE: begin
								if (create_new) begin
									region_valid_q[in_ridx] <= 1'b1;
								end
								done_q   <= 1'b1;
								status_q <= in_range ? STAT_GRANTED : STAT_NO_REGION;
								ticket_q <= '0;
								final_q  <= 1'b1;
							end
							OP_OBTAIN: begin
								if (gcnt_q < GCNT_W'(SET_SIZE)) begin
									gset_q[gcnt_q[IDX_W-1:0]] <= '{region: region, wr: is_write};
									gcnt_q <= gcnt_q + GCNT_W'(1);
								end else begin
									gcnt_q <= GCNT_W'(SET_SIZE + 1);
								end
								mode_rescan_q <= 1'b0;
								if (set_end) begin
									state_q <= ST_F_START;
								end
							end
							OP_RELEASE: begin
								rel_reg_q     <= region;
								rel_wr_q      <= is_write;
								rel_last_q    <= set_end;
								mode_rescan_q <= 1'b1;
								if (in_range && region_valid_q[in_ridx]) begin
									state_q <= ST_R_A;
								end else if (set_end) begin
									rot_q   <= '0;
									pend_q  <= 1'b0;
									state_q <= ST_S_HEAD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_F_START: begin
					n_q    <= N_W'(gcnt_q);
					gcnt_q <= '0;
					idx_q  <= '0;
					if (gcnt_q > GCNT_W'(SET_SIZE)) begin
						done_q   <= 1'b1;
						status_q <= STAT_NO_ROOM;
						ticket_q <= '0;
						final_q  <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_F_VCHK;
					end
				end
				ST_F_VCHK: begin
					if (!cur_known) begin
						done_q   <= 1'b1;
						status_q <= STAT_NO_REGION;
						ticket_q <= '0;
						final_q  <= 1'b1;
						state_q  <= ST_IDLE;
					end else if (chk_last) begin
						idx_q   <= '0;
						state_q <= ST_F_RCHK_A;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_F_RCHK_A: begin
					state_q <= ST_F_RCHK_B;
				end
				ST_F_RCHK_B: begin
					if ((32'(cnt_rd_q) + 32'(same)) > QUEUE_DEPTH) begin
						done_q   <= 1'b1;
						status_q <= STAT_NO_ROOM;
						ticket_q <= '0;
						final_q  <= 1'b1;
						state_q  <= ST_IDLE;
					end else if (chk_last) begin
						idx_q   <= '0;
						state_q <= ST_F_ENQ_A;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= ST_F_RCHK_A;
					end
				end
				ST_F_ENQ_A: begin
					state_q <= ST_F_ENQ_B;
				end
				ST_F_ENQ_B: begin
					saved_q[idx_q] <= ewt_rd_q;
					if (chk_last) begin
						idx_q   <= '0;
						state_q <= ST_G_A;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= ST_F_ENQ_A;
					end
				end
				ST_G_A: begin
					state_q <= ST_G_B;
				end
				ST_G_C: begin
					state_q <= ST_G_D;
				end
				ST_G_B, ST_G_D: begin
					if (g_go_pq) begin
						pq_addr_q <= qaddr(ridx, head_rd_q);
						state_q   <= ST_G_C;
					end else if (g_pass || g_fail) begin
						if (mode_rescan_q) begin
							if (g_pass) begin
								if (pend_q) begin
									done_q   <= 1'b1;
									status_q <= STAT_GRANTED;
									ticket_q <= pend_ticket_q;
									final_q  <= 1'b0;
								end
								pend_q        <= 1'b1;
								pend_ticket_q <= head.ticket;
							end
							rot_q   <= rot_q + RW'(1);
							state_q <= ST_S_HEAD;
						end else if (g_pass) begin
							time_q   <= time_q + TIME_W'(1);
							done_q   <= 1'b1;
							status_q <= STAT_GRANTED;
							ticket_q <= time_q;
							final_q  <= 1'b1;
							state_q  <= ST_IDLE;
						end else if (!chain_full) begin
							time_q   <= time_q + TIME_W'(1);
							done_q   <= 1'b1;
							status_q <= STAT_WAITING;
							ticket_q <= time_q;
							final_q  <= 1'b1;
							state_q  <= ST_IDLE;
						end else begin
							// standby full: take the set back out of the queues
							idx_q   <= IDX_W'(n_q - N_W'(1));
							state_q <= ST_W_A;
						end
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= ST_G_A;
					end
				end
				ST_W_A: begin
					state_q <= ST_W_B;
				end
				ST_W_B: begin
					if (idx_q == '0) begin
						done_q   <= 1'b1;
						status_q <= STAT_NO_ROOM;
						ticket_q <= '0;
						final_q  <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						idx_q   <= idx_q - IDX_W'(1);
						state_q <= ST_W_A;
					end
				end
				ST_R_A: begin
					state_q <= ST_R_B;
				end
				ST_R_B, ST_R_SCAN_A, ST_R_SCAN_C: begin
					if (((state_q == ST_R_B) && pop_any && rel_wr_q)
						|| ((state_q == ST_R_SCAN_C) && !pq_rd_q[TIME_W])) begin
						// keep walking for the next queued write
						if (state_q == ST_R_B) begin
							rhead_q  <= ring_add(head_rd_q, CW'(1));
							rcnt_q   <= cnt_rd_q - CW'(1);
							scan_i_q <= '0;
						end else begin
							scan_i_q <= scan_i_q + CW'(1);
						end
						state_q <= ST_R_SCAN_A;
					end else if ((state_q == ST_R_SCAN_A) && (scan_i_q != rcnt_q)) begin
						pq_addr_q <= qaddr(ridx, ring_add(rhead_q, scan_i_q));
						state_q   <= ST_R_SCAN_B;
					end else if (rel_last_q) begin
						rot_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= ST_S_HEAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_R_SCAN_B: begin
					state_q <= ST_R_SCAN_C;
				end
				ST_S_HEAD: begin
					if (rot_q == RW'(STANDBY_DEPTH)) begin
						rot_q   <= '0;
						state_q <= ST_S_COMP;
					end else if (!head.valid) begin
						rot_q <= rot_q + RW'(1);
					end else begin
						idx_q   <= '0;
						state_q <= ST_G_A;
					end
				end
				ST_S_COMP: begin
					if (rot_q == RW'(STANDBY_DEPTH - 1)) begin
						done_q   <= 1'b1;
						status_q <= STAT_GRANTED;
						ticket_q <= pend_q ? pend_ticket_q : '0;
						final_q  <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						rot_q <= rot_q + RW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign ticket       = ticket_q;
	assign final_result = final_q;

	// a create of a known index leaves the region valid
	a_create_valid: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (operation == OP_CREATE) && in_range |=> region_valid_q[$past(in_ridx)])
		else $error("region not valid after create");

	// standby sets stay packed at the head whenever no request is in work
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> sb_packed)
		else $error("standby chain has a gap while idle");

	// a result that is not the last one means more are still being produced
	a_more_results: assert property (@(posedge clk) disable iff (!arst_n)
		done && !final_result |-> busy)
		else $error("intermediate result with block idle");

	// a waiting result always ends its request
	a_wait_final: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STAT_WAITING) |-> final_result)
		else $error("waiting result not final");

	// gather count never passes the overflow mark
	a_gcnt: assert property (@(posedge clk) disable iff (!arst_n)
		gcnt_q <= GCNT_W'(SET_SIZE + 1))
		else $error("gather count out of range");

endmodule

// File: sim/timestamp_region_lock_manager_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_region_lock_manager_test
// self-checking bench: requests are fed from a queue by a clocked driver in
// random bursts, a timestamp-ordering predictor computes the lock results of
// every accepted request and the monitor compares each strobed result
// ----------------------------------------------------------------------------
module timestamp_region_lock_manager_test;
	import trlm_pkg::*;

	localparam int N_REG   = 64;
	localparam int Q_DEPTH = 16;
	localparam int SB_DEPTH = 16;
	localparam int IDLE_LIMIT = 5000;
	localparam logic [1:0] OP_IGNORED = 2'd3;

	// one request as the driver sees it; hold marks a pause until drained
	typedef struct packed {
		bit                  hold;
		logic [1:0]          op;
		logic [REGION_W-1:0] rg;
		logic                wr;
		logic                last;
	} req_t;

	typedef struct packed {
		logic [1:0]        st;
		logic [TIME_W-1:0] tk;
		logic              fin;
	} lock_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] operation = OP_CREATE;
	logic [REGION_W-1:0] region = '0;
	logic is_write = 1'b0;
	logic set_end = 1'b0;
	logic busy, done, final_result;
	logic [1:0] status;
	logic [TIME_W-1:0] ticket;

	timestamp_region_lock_manager dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .region(region), .is_write(is_write),
		.set_end(set_end), .done(done), .status(status), .ticket(ticket),
		.final_result(final_result)
	);

	always #2 clk = ~clk;

	req_t         pending_reqs[$];
	lock_result_t awaited_results[$];
	int           fail_count = 0;
	int           idle_cycles = 0;

	// ---------------------------------------------------------------- predictor
	bit                  rvalid[N_REG];
	logic [32:0]         pend[N_REG][Q_DEPTH];
	int                  qhead[N_REG];
	int                  qcount[N_REG];
	logic [TIME_W-1:0]   first_write[N_REG];
	logic [TIME_W-1:0]   now_time;
	logic [3:0][5:0]     gath_rg;
	logic [3:0]          gath_wr;
	int                  gath_n;
	logic [3:0][5:0]     sb_rg[SB_DEPTH];
	logic [3:0]          sb_wr[SB_DEPTH];
	int                  sb_n[SB_DEPTH];
	logic [TIME_W-1:0]   sb_tk[SB_DEPTH];
	bit                  sb_valid[SB_DEPTH];

	task automatic push_result(input logic [1:0] st, input logic [TIME_W-1:0] tk,
			input logic fin);
		lock_result_t x;
		x.st = st;
		x.tk = tk;
		x.fin = fin;
		awaited_results.push_back(x);
	endtask

	// read ok if not after earliest write; write ok if not after queue head
	function automatic bit set_can_lock(input logic [3:0][5:0] rr, input logic [3:0] ww,
			input int n, input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] conflict;
		int r;
		for (int i = 0; i < n; i++) begin
			r = rr[i];
			if (ww[i]) begin
				if (qcount[r] == 0) continue;
				conflict = pend[r][qhead[r]][31:0];
			end else begin
				conflict = first_write[r];
			end
			if (t > conflict) return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic pop_head(input int r, input logic wr);
		logic [32:0] ent;
		if (qcount[r] == 0) return;
		qhead[r] = (qhead[r] + 1) % Q_DEPTH;
		qcount[r]--;
		if (!wr) return;
		first_write[r] = NO_WRITE;
		for (int i = 0; i < qcount[r]; i++) begin
			ent = pend[r][(qhead[r] + i) % Q_DEPTH];
			if (ent[32]) begin
				first_write[r] = ent[31:0];
				break;
			end
		end
	endtask

	task automatic close_obtain_set();
		int n, same, r, used;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] saved[4];
		n = gath_n;
		t = now_time;
		used = 0;
		gath_n = 0;
		if (n > SET_SIZE) begin
			push_result(STAT_NO_ROOM, '0, 1'b1);
			return;
		end
		for (int i = 0; i < n; i++)
			if (!rvalid[gath_rg[i]]) begin
				push_result(STAT_NO_REGION, '0, 1'b1);
				return;
			end
		for (int i = 0; i < n; i++) begin
			same = 0;
			for (int j = 0; j < n; j++)
				if (gath_rg[j] == gath_rg[i]) same++;
			if (qcount[gath_rg[i]] + same > Q_DEPTH) begin
				push_result(STAT_NO_ROOM, '0, 1'b1);
				return;
			end
		end
		for (int i = 0; i < n; i++) begin
			r = gath_rg[i];
			saved[i] = first_write[r];
			pend[r][(qhead[r] + qcount[r]) % Q_DEPTH] = {gath_wr[i], t};
			qcount[r]++;
			if (gath_wr[i] && t < first_write[r]) first_write[r] = t;
		end
		if (set_can_lock(gath_rg, gath_wr, n, t)) begin
			now_time = t + 1;
			push_result(STAT_GRANTED, t, 1'b1);
			return;
		end
		while (used < SB_DEPTH && sb_valid[used]) used++;
		if (used < SB_DEPTH) begin
			sb_tk[used] = t;
			sb_n[used] = n;
			sb_rg[used] = gath_rg;
			sb_wr[used] = gath_wr;
			sb_valid[used] = 1'b1;
			now_time = t + 1;
			push_result(STAT_WAITING, t, 1'b1);
			return;
		end
		// standby full: withdraw the set again, newest entry first
		for (int i = n - 1; i >= 0; i--) begin
			qcount[gath_rg[i]]--;
			first_write[gath_rg[i]] = saved[i];
		end
		push_result(STAT_NO_ROOM, '0, 1'b1);
	endtask

	task automatic rescan_standby();
		logic [TIME_W-1:0] granted[$];
		int w;
		w = 0;
		for (int i = 0; i < SB_DEPTH && sb_valid[i]; i++) begin
			if (set_can_lock(sb_rg[i], sb_wr[i], sb_n[i], sb_tk[i])) begin
				granted.push_back(sb_tk[i]);
			end else begin
				sb_tk[w] = sb_tk[i];
				sb_n[w] = sb_n[i];
				sb_rg[w] = sb_rg[i];
				sb_wr[w] = sb_wr[i];
				w++;
			end
		end
		for (int i = 0; i < SB_DEPTH; i++) sb_valid[i] = (i < w);
		if (granted.size() == 0) push_result(STAT_GRANTED, '0, 1'b1);
		foreach (granted[i])
			push_result(STAT_GRANTED, granted[i], i == granted.size() - 1);
	endtask

	task automatic predict_request(input req_t q);
		int r;
		r = q.rg;
		case (q.op)
			OP_CREATE: begin
				if (!rvalid[r]) begin
					rvalid[r] = 1'b1;
					qhead[r] = 0;
					qcount[r] = 1;
					pend[r][0] = {1'b1, 32'd0};
					first_write[r] = '0;
				end
				push_result(STAT_GRANTED, '0, 1'b1);
			end
			OP_OBTAIN: begin
				if (gath_n < SET_SIZE) begin
					gath_rg[gath_n] = q.rg;
					gath_wr[gath_n] = q.wr;
					gath_n++;
				end else begin
					gath_n = SET_SIZE + 1;
				end
				if (q.last) close_obtain_set();
			end
			OP_RELEASE: begin
				if (rvalid[r]) pop_head(r, q.wr);
				if (q.last) rescan_standby();
			end
			default: ;
		endcase
	endtask

	initial begin
		for (int r = 0; r < N_REG; r++) begin
			rvalid[r] = 1'b0;
			qhead[r] = 0;
			qcount[r] = 0;
			first_write[r] = '0;
		end
		for (int i = 0; i < SB_DEPTH; i++) sb_valid[i] = 1'b0;
		now_time = 1;
		gath_n = 0;
	end

	// ------------------------------------------------------------------ driver
	// fields change on the falling edge; a raised start stays up until taken
	bit          took = 1'b0;
	int          gap_left = 0;
	int          burst_left = 4;
	req_t        cur_req;

	always @(negedge clk) begin
		if (arst_n && (!start || took)) begin
			if (pending_reqs.size() > 0 && pending_reqs[0].hold) begin
				// pressure: sender holds off until every result is in
				if (awaited_results.size() == 0 && !took) void'(pending_reqs.pop_front());
				start <= 1'b0;
			end else if (pending_reqs.size() == 0 || gap_left > 0) begin
				if (gap_left > 0) gap_left--;
				start <= 1'b0;
			end else begin
				cur_req = pending_reqs.pop_front();
				operation <= cur_req.op;
				region <= cur_req.rg;
				is_write <= cur_req.wr;
				set_end <= cur_req.last;
				start <= 1'b1;
				if (--burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// ------------------------------------------------------- monitor / checker
	// prediction runs when a request is taken, before any of its results is
	// strobed, so each result already has its expectation waiting
	always @(posedge clk) begin
		lock_result_t want;
		if (arst_n) begin
			took <= start && !busy;
			if (start && !busy) predict_request(cur_req);
			if (done) begin
				if (awaited_results.size() == 0) begin
					$error("result with nothing expected: status %0d ticket %0d",
						status, ticket);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, actual %0d", want.st, status);
						fail_count++;
					end
					if (ticket !== want.tk) begin
						$error("ticket: expected %0d, actual %0d", want.tk, ticket);
						fail_count++;
					end
					if (final_result !== want.fin) begin
						$error("final_result: expected %0d, actual %0d",
							want.fin, final_result);
						fail_count++;
					end
				end
			end
			// watchdog on stretches with no progress at all
			if ((start && !busy) || done) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// --------------------------------------------------------------- stimulus
	task automatic add_req(input logic [1:0] op, input int rg, input logic wr,
			input logic last);
		req_t q;
		q.hold = 1'b0;
		q.op = op;
		q.rg = rg[REGION_W-1:0];
		q.wr = wr;
		q.last = last;
		pending_reqs.push_back(q);
	endtask

	task automatic add_pause();
		req_t q;
		q = '0;
		q.hold = 1'b1;
		pending_reqs.push_back(q);
	endtask

	// mostly a handful of hot regions so queues fill and sets conflict
	function automatic int pick_region();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
	endfunction

	initial begin
		int n, made, kind;
		// directed part
		add_req(OP_CREATE, 0, 0, 1);
		add_req(OP_CREATE, 63, 1, 1);
		add_req(OP_CREATE, 0, 0, 1);               // already valid
		add_req(OP_OBTAIN, 0, 0, 1);               // read behind the create write
		add_req(OP_OBTAIN, 9, 1, 1);               // region never created
		for (int i = 0; i < 5; i++)                // overflowed set
			add_req(OP_OBTAIN, 63, i[0], i == 4);
		add_req(OP_IGNORED, 42, 1, 1);
		add_req(OP_RELEASE, 17, 1, 1);             // invalid region
		add_req(OP_RELEASE, 0, 1, 0);
		add_req(OP_RELEASE, 63, 1, 1);             // releases wake standby
		add_req(OP_OBTAIN, 63, 1, 0);
		add_req(OP_OBTAIN, 0, 0, 1);
		add_req(OP_RELEASE, 0, 0, 1);
		add_req(OP_RELEASE, 0, 0, 1);              // empties the queue
		add_pause();
		// fill standby past its depth with reads behind unreleased writes
		for (int r = 2; r < 6; r++) add_req(OP_CREATE, r, 0, 1);
		for (int i = 0; i < SB_DEPTH + 2; i++) add_req(OP_OBTAIN, 2 + i % 4, 0, 1);
		for (int r = 2; r < 6; r++) add_req(OP_RELEASE, r, 1, r == 5);
		add_pause();
		made = 40;
		// random part
		while (made < 450) begin
			kind = $urandom_range(0, 99);
			if (kind < 10) begin
				add_req(OP_CREATE, pick_region(), $urandom_range(0, 1), $urandom_range(0, 1));
				made++;
			end else if (kind < 55) begin
				n = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					add_req(OP_OBTAIN, pick_region(), $urandom_range(0, 1), i == n - 1);
				made += n;
			end else if (kind < 92) begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					add_req(OP_RELEASE, pick_region(), $urandom_range(0, 1), i == n - 1);
				made += n;
			end else if (kind < 96) begin
				add_req(OP_IGNORED, $urandom_range(0, 63), $urandom_range(0, 1),
					$urandom_range(0, 1));
			end else begin
				add_pause();
			end
		end
		// final release rescans the standby chain
		add_req(OP_RELEASE, 0, 0, 1);

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		while (pending_reqs.size() > 0 || start || awaited_results.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0 && awaited_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: files.f
hdl/trlm_pkg.sv
hdl/trlm_cell.sv
hdl/timestamp_region_lock_manager.sv
sim/timestamp_region_lock_manager_test.sv
